FILE: src/hsfd_pkg.sv
// shared types, constants and the crc step for the sensor frame decoder
package hsfd_pkg;

	// crc and scaling constants
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] POLY_RESET = 8'h31;
	localparam int unsigned TEMP_SCALE = 17500;
	localparam int unsigned HUM_SCALE = 10000;
	localparam int unsigned TEMP_OFFSET = 4500;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// product widths: 17500*65535 < 2^31, 10000*65535 < 2^30
	localparam int unsigned TEMP_PROD_W = 31;
	localparam int unsigned HUM_PROD_W = 30;

	// position of a byte within the six-byte frame
	typedef enum logic [2:0] {
		POS_TEMP_HI  = 3'd0,
		POS_TEMP_LO  = 3'd1,
		POS_TEMP_CRC = 3'd2,
		POS_HUM_HI   = 3'd3,
		POS_HUM_LO   = 3'd4,
		POS_HUM_CRC  = 3'd5
	} hsfd_pos_t;

	// one received byte
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} hsfd_in_t;

	// one measurement result
	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [13:0]        humidity_centi;
		logic               temp_crc_ok;
		logic               hum_crc_ok;
		logic               values_updated;
	} hsfd_out_t;

	// checked frame handed from front to back
	typedef struct packed {
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
		logic        temp_ok;
		logic        hum_ok;
	} hsfd_job_t;

	// queue write request
	typedef struct packed {
		logic      valid;
		hsfd_job_t job;
	} hsfd_push_t;

	// msb-first crc-8 over one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: src/hsfd_front.sv
// front end: byte sequencing, crc check and word assembly
module hsfd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  hsfd_pkg::hsfd_in_t in_req,
	input  logic [7:0]       poly,
	output hsfd_pkg::hsfd_push_t push
);
	import hsfd_pkg::*;

	hsfd_pos_t   pos_q, pos_d, eff_pos;
	logic [7:0]  crc_q, crc_d, crc_base, crc_next;
	logic [7:0]  hi_q, hi_d;
	logic [15:0] temp_raw_q, temp_raw_d;
	logic [15:0] hum_raw_q, hum_raw_d;
	logic        temp_ok_q, temp_ok_d;
	logic        restart;

	// frame start or an unused position restarts the frame
	assign restart  = in_req.frame_start || (pos_q > POS_HUM_CRC);
	assign eff_pos  = restart ? POS_TEMP_HI : pos_q;
	assign crc_base = restart ? CRC_INIT : crc_q;
	assign crc_next = crc8_byte(crc_base, in_req.rx_byte, poly);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_TEMP_HI;
			crc_q     <= CRC_INIT;
			temp_ok_q <= 1'b0;
		end else if (accept) begin
			pos_q     <= pos_d;
			crc_q     <= crc_d;
			temp_ok_q <= temp_ok_d;
		end
	end

	// word registers
	always_ff @(posedge clk) begin
		if (accept) begin
			hi_q       <= hi_d;
			temp_raw_q <= temp_raw_d;
			hum_raw_q  <= hum_raw_d;
		end
	end

	// next state per byte position
	always_comb begin
		pos_d      = POS_TEMP_HI;
		crc_d      = crc_next;
		hi_d       = hi_q;
		temp_raw_d = temp_raw_q;
		hum_raw_d  = hum_raw_q;
		temp_ok_d  = temp_ok_q;
		push.valid = 1'b0;
		push.job.temp_raw = temp_raw_q;
		push.job.hum_raw  = hum_raw_q;
		push.job.temp_ok  = temp_ok_q;
		push.job.hum_ok   = (crc_base == in_req.rx_byte);
		unique case (eff_pos)
			POS_TEMP_HI: begin
				hi_d  = in_req.rx_byte;
				pos_d = POS_TEMP_LO;
			end
			POS_TEMP_LO: begin
				temp_raw_d = {hi_q, in_req.rx_byte};
				pos_d      = POS_TEMP_CRC;
			end
			POS_TEMP_CRC: begin
				temp_ok_d = (crc_base == in_req.rx_byte);
				crc_d     = CRC_INIT;
				pos_d     = POS_HUM_HI;
			end
			POS_HUM_HI: begin
				hi_d  = in_req.rx_byte;
				pos_d = POS_HUM_LO;
			end
			POS_HUM_LO: begin
				hum_raw_d = {hi_q, in_req.rx_byte};
				pos_d     = POS_HUM_CRC;
			end
			POS_HUM_CRC: begin
				push.valid = accept;
				crc_d      = CRC_INIT;
				pos_d      = POS_TEMP_HI;
			end
			default: begin
				pos_d = POS_TEMP_HI;
			end
		endcase
	end

	// a finished frame leaves the crc and position cleared
	a_push_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |=> (pos_q == POS_TEMP_HI) && (crc_q == CRC_INIT))
		else $error("front not cleared after frame");

	// a flagged start byte is always taken as the temperature high byte
	a_start_resync: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_req.frame_start) |=> (pos_q == POS_TEMP_LO))
		else $error("frame start did not resync");

	// the humidity word always starts from a fresh crc
	a_hum_crc_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == POS_HUM_HI) |-> (crc_q == CRC_INIT))
		else $error("humidity crc not restarted");

endmodule

FILE: src/hsfd_queue.sv
// short queue of checked frames between front and back
module hsfd_queue #(
	parameter int unsigned DEPTH = hsfd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hsfd_pkg::hsfd_push_t push,
	input  logic                 pop,
	output hsfd_pkg::hsfd_job_t  head,
	output logic                 head_valid,
	output logic                 full
);
	import hsfd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	hsfd_job_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// no write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full))
		else $error("queue overflow");

	// fill count never exceeds depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

	// a lone write grows the count by one
	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count mismatch");

endmodule

FILE: src/hsfd_back.sv
// back end: value scaling, held values and result register
module hsfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hsfd_pkg::hsfd_job_t job,
	input  logic                job_valid,
	output logic                pop,
	output logic                meas_valid,
	input  logic                meas_stall,
	output hsfd_pkg::hsfd_out_t meas_req
);
	import hsfd_pkg::*;

	// floor(x / 65535) for x < 2^31: one correction step
	function automatic logic [14:0] div65535(input logic [TEMP_PROD_W-1:0] x);
		logic [14:0] q0;
		logic [16:0] r;
		q0 = x[TEMP_PROD_W-1:16];
		r  = {1'b0, x[15:0]} + {2'b00, q0};
		return q0 + 15'(r >= 17'd65535);
	endfunction

	logic                   enable;
	logic                   valid_s1;
	logic [TEMP_PROD_W-1:0] temp_prod_s1;
	logic [HUM_PROD_W-1:0]  hum_prod_s1;
	logic                   temp_ok_s1, hum_ok_s1;
	logic [14:0]            temp_q15;
	logic [14:0]            hum_q15;
	logic signed [14:0]     temp_new;
	logic [13:0]            hum_new;
	logic                   upd;
	logic signed [14:0]     held_temp_q;
	logic [13:0]            held_hum_q;
	logic                   out_valid_q;
	hsfd_out_t              out_q;

	// pipeline moves when the result register is free or being taken
	assign enable     = !out_valid_q || !meas_stall;
	assign pop        = enable && job_valid;
	assign meas_valid = out_valid_q;
	assign meas_req   = out_q;

	// stage 1: constant multiplies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enable) begin
			valid_s1 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			temp_prod_s1 <= TEMP_PROD_W'(TEMP_SCALE) * TEMP_PROD_W'(job.temp_raw);
			hum_prod_s1  <= HUM_PROD_W'(HUM_SCALE) * HUM_PROD_W'(job.hum_raw);
			temp_ok_s1   <= job.temp_ok;
			hum_ok_s1    <= job.hum_ok;
		end
	end

	// stage 2: divide by 65535 and offset
	assign temp_q15 = div65535(temp_prod_s1);
	assign hum_q15  = div65535({1'b0, hum_prod_s1});
	assign temp_new = $signed(temp_q15 - 15'(TEMP_OFFSET));
	assign hum_new  = hum_q15[13:0];
	assign upd      = temp_ok_s1 && hum_ok_s1;

	// held values and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_temp_q <= '0;
			held_hum_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (enable) begin
			out_valid_q <= valid_s1;
			if (valid_s1 && upd) begin
				held_temp_q <= temp_new;
				held_hum_q  <= hum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enable && valid_s1) begin
			out_q.temperature_centi <= upd ? temp_new : held_temp_q;
			out_q.humidity_centi    <= upd ? hum_new : held_hum_q;
			out_q.temp_crc_ok       <= temp_ok_s1;
			out_q.hum_crc_ok        <= hum_ok_s1;
			out_q.values_updated    <= upd;
		end
	end

	// an update is only reported when both words checked out
	a_upd_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(meas_valid && meas_req.values_updated) |->
			(meas_req.temp_crc_ok && meas_req.hum_crc_ok))
		else $error("update without both crc passes");

	// held humidity stays within full scale
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_hum_q <= 14'(HUM_SCALE))
		else $error("held humidity out of range");

	// held values only change on a passing frame
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(enable && valid_s1 && upd) |=> ($stable(held_temp_q) && $stable(held_hum_q)))
		else $error("held values changed without update");

endmodule

FILE: src/humidity_sensor_frame_decoder.sv
// top level of the humidity and temperature sensor frame decoder
//
// frame channel: frame_valid/frame_stall/frame_req carry one received byte per
// request, with frame_start marking the first byte of a six-byte frame
// (temperature hi, lo, crc, humidity hi, lo, crc). a byte is taken at a clock
// edge with frame_valid high and frame_stall low.
// meas channel: meas_valid/meas_stall/meas_req carry one result per complete
// frame: crc flags, update flag and the held temperature and humidity.
// cfg_we/cfg_wdata write the crc-8 polynomial (0x31 after reset).
// throughput: one byte per cycle while frame_stall is low; the byte crc and the constant scaling keep up.
// the sixth byte goes into the queue at the edge that takes it; the result
// then passes the multiply stage and the divide stage into the result
// register.
// when meas_stall holds the result, the back end stops; up to QUEUE_DEPTH
// finished frames wait in the queue, and frame_stall rises once it is full.
// reset clears the frame position, the crc, the queue and the held values
// (temperature and humidity read zero until a frame passes both checks).
module humidity_sensor_frame_decoder #(
	parameter int unsigned QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	output logic                frame_stall,
	input  hsfd_pkg::hsfd_in_t  frame_req,
	output logic                meas_valid,
	input  logic                meas_stall,
	output hsfd_pkg::hsfd_out_t meas_req,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);
	import hsfd_pkg::*;

	logic       poly_q;
	logic [7:0] poly_r_q;
	logic       accept;
	logic       full;
	logic       pop;
	logic       head_valid;
	hsfd_push_t push;
	hsfd_job_t  head;

	// polynomial register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_r_q <= POLY_RESET;
			poly_q   <= 1'b0;
		end else if (cfg_we) begin
			poly_r_q <= cfg_wdata;
			poly_q   <= 1'b1;
		end
	end

	// input handshake
	assign frame_stall = full;
	assign accept      = frame_valid && !full;

	hsfd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.in_req (frame_req),
		.poly   (poly_r_q),
		.push   (push)
	);

	hsfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	hsfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (head),
		.job_valid  (head_valid),
		.pop        (pop),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.meas_req   (meas_req)
	);

	// a polynomial write after the first never lands in the same cycle as a finished frame's queue push
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && poly_q) |-> !(push.valid))
		else $error("polynomial written during frame completion");

endmodule

FILE: tb/testbench.sv
// testbench for the humidity sensor frame decoder: crc check and value scaling
`timescale 1ns / 100ps

module testbench;
	import hsfd_pkg::*;

	localparam int unsigned FULL_SCALE = 65535;
	localparam int unsigned SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        frame_valid = 1'b0;
	logic        frame_stall;
	hsfd_in_t    frame_req = '0;
	logic        meas_valid;
	logic        meas_stall = 1'b0;
	hsfd_out_t   meas_req;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	// decoder model state
	logic [7:0]         crc_poly = POLY_RESET;
	hsfd_pos_t          frame_pos = POS_TEMP_HI;
	logic [7:0]         frame_crc = CRC_INIT;
	logic [7:0]         word_hi;
	logic [15:0]        temp_word;
	logic [15:0]        hum_word;
	logic               temp_word_ok = 1'b0;
	logic signed [14:0] held_temp = '0;
	logic [13:0]        held_hum = '0;

	hsfd_out_t expected_meas[$];
	hsfd_out_t want_meas;
	int        failures = 0;
	int        bytes_sent = 0;
	int        gap_pct = 0;
	int        stall_pct = 0;
	int        stall_left = 0;

	humidity_sensor_frame_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_req  (frame_req),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.meas_req   (meas_req),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bit-serial crc-8, data fed msb first
	function automatic logic [7:0] crc_update(logic [7:0] c, logic [7:0] d, logic [7:0] poly);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c = {c[6:0], 1'b0} ^ (fb ? poly : 8'h00);
		end
		return c;
	endfunction

	function automatic logic signed [14:0] temp_centi(logic [15:0] raw);
		int unsigned q;
		int v;
		q = (TEMP_SCALE * raw) / FULL_SCALE;
		v = int'(q) - int'(TEMP_OFFSET);
		return v[14:0];
	endfunction

	function automatic logic [13:0] hum_centi(logic [15:0] raw);
		int unsigned q;
		q = (HUM_SCALE * raw) / FULL_SCALE;
		return q[13:0];
	endfunction

	// advance the frame model by one accepted byte
	task automatic decode_byte(logic [7:0] b, logic st);
		logic      hum_ok;
		hsfd_out_t r;
		if (st) begin
			frame_pos = POS_TEMP_HI;
			frame_crc = CRC_INIT;
		end
		case (frame_pos)
			POS_TEMP_HI, POS_HUM_HI: begin
				frame_crc = crc_update(frame_crc, b, crc_poly);
				word_hi = b;
				frame_pos = (frame_pos == POS_TEMP_HI) ? POS_TEMP_LO : POS_HUM_LO;
			end
			POS_TEMP_LO: begin
				frame_crc = crc_update(frame_crc, b, crc_poly);
				temp_word = {word_hi, b};
				frame_pos = POS_TEMP_CRC;
			end
			POS_TEMP_CRC: begin
				temp_word_ok = (frame_crc == b);
				frame_crc = CRC_INIT;
				frame_pos = POS_HUM_HI;
			end
			POS_HUM_LO: begin
				frame_crc = crc_update(frame_crc, b, crc_poly);
				hum_word = {word_hi, b};
				frame_pos = POS_HUM_CRC;
			end
			default: begin
				// humidity crc byte closes the frame
				hum_ok = (frame_crc == b);
				if (hum_ok && temp_word_ok) begin
					held_temp = temp_centi(temp_word);
					held_hum = hum_centi(hum_word);
				end
				r.temperature_centi = held_temp;
				r.humidity_centi = held_hum;
				r.temp_crc_ok = temp_word_ok;
				r.hum_crc_ok = hum_ok;
				r.values_updated = hum_ok && temp_word_ok;
				expected_meas.push_back(r);
				frame_pos = POS_TEMP_HI;
				frame_crc = CRC_INIT;
			end
		endcase
	endtask

	// one byte request, with an optional idle burst in front
	task automatic send_byte(logic [7:0] b, logic st);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			frame_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		frame_valid <= 1'b1;
		frame_req <= '{rx_byte: b, frame_start: st};
		do @(posedge clk); while (frame_stall);
		decode_byte(b, st);
		bytes_sent++;
	endtask

	// six-byte frame, each crc either correct or corrupted
	task automatic send_frame(logic [15:0] t, logic [15:0] h, logic t_good, logic h_good,
			logic st);
		logic [7:0] tc;
		logic [7:0] hc;
		tc = crc_update(crc_update(CRC_INIT, t[15:8], crc_poly), t[7:0], crc_poly);
		hc = crc_update(crc_update(CRC_INIT, h[15:8], crc_poly), h[7:0], crc_poly);
		if (!t_good) tc ^= 8'($urandom_range(1, 255));
		if (!h_good) hc ^= 8'($urandom_range(1, 255));
		send_byte(t[15:8], st);
		send_byte(t[7:0], 1'b0);
		send_byte(tc, 1'b0);
		send_byte(h[15:8], 1'b0);
		send_byte(h[7:0], 1'b0);
		send_byte(hc, 1'b0);
	endtask

	// hold the sender until every pending result is out
	task automatic drain_results();
		frame_valid <= 1'b0;
		while (expected_meas.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_no_good_frame();
		// bad temperature crc before any good frame: held values stay zero
		send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1);
	endtask

	task automatic test_scale_extremes();
		send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		// next frame without the start flag
		send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);
	endtask

	task automatic test_resync_mid_frame();
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		// good temperature, bad humidity: values held
		send_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b1);
	endtask

	task automatic test_set_polynomial(logic [7:0] poly);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= poly;
		@(posedge clk);
		cfg_we <= 1'b0;
		crc_poly = poly;
	endtask

	// mostly well-formed frames with random content, some stray bytes
	task automatic test_random_traffic(int n, bit idle);
		int stop_at;
		int next_mode;
		stop_at = bytes_sent + n;
		next_mode = bytes_sent;
		while (bytes_sent < stop_at) begin
			if (bytes_sent >= next_mode) begin
				gap_pct = idle ? 15 * $urandom_range(0, 2) : 0;
				stall_pct = idle ? 15 * $urandom_range(0, 2) : 0;
				next_mode = bytes_sent + 120;
			end
			if ($urandom_range(0, 4) != 0) begin
				send_frame(pick_raw(), pick_raw(), $urandom_range(0, 6) != 0,
					$urandom_range(0, 6) != 0, $urandom_range(0, 1));
			end else begin
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
			end
		end
		// leave the frame aligned
		send_frame(pick_raw(), pick_raw(), 1'b1, 1'b1, 1'b1);
	endtask

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			meas_stall <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 6);
			meas_stall <= 1'b1;
		end else begin
			meas_stall <= 1'b0;
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// compare each measurement with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && meas_valid && !meas_stall) begin
			if (expected_meas.size() == 0) begin
				$display("%0t: unexpected measurement, expected none, got %p", $time, meas_req);
				failures++;
			end else begin
				want_meas = expected_meas.pop_front();
				check_field("temperature_centi", want_meas.temperature_centi,
					meas_req.temperature_centi);
				check_field("humidity_centi", want_meas.humidity_centi, meas_req.humidity_centi);
				check_field("temp_crc_ok", want_meas.temp_crc_ok, meas_req.temp_crc_ok);
				check_field("hum_crc_ok", want_meas.hum_crc_ok, meas_req.hum_crc_ok);
				check_field("values_updated", want_meas.values_updated,
					meas_req.values_updated);
			end
		end
	end

	// test sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_good_frame();
		test_scale_extremes();
		test_resync_mid_frame();
		test_set_polynomial(8'h00);
		test_random_traffic(350, 1'b1);
		test_set_polynomial(8'hFF);
		test_random_traffic(350, 1'b1);
		test_set_polynomial(8'($urandom));
		test_random_traffic(350, 1'b1);
		test_set_polynomial(POLY_RESET);
		test_random_traffic(350, 1'b1);
		test_random_traffic(250, 1'b0);
		drain_results();
		if (failures == 0 && expected_meas.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
